FILE: hw/rtl/min_window_covering_pattern_assert.svh
// Assertion macros for the minimum covering window block.
`ifndef MIN_WINDOW_COVERING_PATTERN_ASSERT_SVH
`define MIN_WINDOW_COVERING_PATTERN_ASSERT_SVH
`ifndef SYNTHESIS
`define MWC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MWC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MWC_ASSERT_IMP(label, clk, rst, ante, cons)
`define MWC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/mwc_pkg.sv
// ----------------------------------------------------------------------------
// mwc_pkg
// Types, constants and command structs shared by the covering window block.
// ----------------------------------------------------------------------------
package mwc_pkg;
  localparam int MaxText  = 4096;
  localparam int Alphabet = 256;
  localparam int PosW     = $clog2(MaxText);
  localparam int LenW     = PosW + 1;
  localparam int SymW     = $clog2(Alphabet);

  localparam logic [1:0] ActPattern = 2'd0;
  localparam logic [1:0] ActText    = 2'd1;
  localparam logic [1:0] ActEnd     = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [11:0] window_start;
    logic [12:0] window_length;
    logic        overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StClear, StPatRd, StPatWr, StTxtRd, StTxtWr,
    StHistRd, StCntRd, StCntChk, StEmit
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic clr_start;
    logic clr_step;
    logic pat_rd;
    logic pat_wr;
    logic txt_rd;
    logic txt_wr;
    logic cnt_rd;
    logic shrink_apply;
    logic record_best;
    logic set_ovf;
    logic emit_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic pat_full;
    logic txt_full;
    logic text_started;
    logic pat_empty;
    logic covered;
    logic left_in_range;
    logic can_shrink;
  } stat_t;
endpackage

FILE: hw/rtl/mwc_ram.sv
// ----------------------------------------------------------------------------
// mwc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mwc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/mwc_datapath.sv
// ----------------------------------------------------------------------------
// mwc_datapath
// Count memories, text history, window registers and best-window record.
// ----------------------------------------------------------------------------
module mwc_datapath
  import mwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_item_t result
);
  logic [SymW-1:0] sym;
  logic [SymW-1:0] clr_idx;
  logic            clr_last;
  logic [LenW-1:0] pat_len;
  logic [LenW-1:0] txt_pos;
  logic [PosW-1:0] left;
  logic [LenW-1:0] covered;
  logic [PosW-1:0] best_start;
  logic [LenW-1:0] best_len;
  logic            ovf;
  logic [SymW-1:0] hsym;

  logic            pc_we, wc_we;
  logic [SymW-1:0] pc_waddr, wc_waddr, pc_raddr, wc_raddr;
  logic [LenW-1:0] pc_wdata, wc_wdata, pc_rdata, wc_rdata;
  logic [7:0]      hist_rdata;
  logic [LenW-1:0] wc_inc, win_len;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      sym <= in_item.data_byte[SymW-1:0];
    end
  end

  assign wc_inc = wc_rdata + LenW'(1);

  // Clearing sweep clears both count memories one entry a cycle.
  always_comb begin
    pc_we = 1'b0; wc_we = 1'b0;
    pc_waddr = sym; wc_waddr = sym;
    pc_wdata = pc_rdata + LenW'(1); wc_wdata = wc_inc;
    pc_raddr = sym; wc_raddr = sym;
    if (cmd.clr_step) begin
      pc_we = 1'b1; wc_we = 1'b1;
      pc_waddr = clr_idx; wc_waddr = clr_idx;
      pc_wdata = '0; wc_wdata = '0;
    end else if (cmd.pat_wr) begin
      pc_we = 1'b1;
    end else if (cmd.txt_wr) begin
      wc_we = 1'b1;
    end else if (cmd.shrink_apply && stat.can_shrink) begin
      wc_we    = 1'b1;
      wc_waddr = hsym;
      wc_wdata = wc_rdata - LenW'(1);
    end
    if (cmd.cnt_rd) begin
      pc_raddr = hist_rdata[SymW-1:0];
      wc_raddr = hist_rdata[SymW-1:0];
    end
  end

  mwc_ram #(.Width(LenW), .Depth(Alphabet)) u_pat_cnt (
    .clk, .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .raddr(pc_raddr), .rdata(pc_rdata)
  );

  mwc_ram #(.Width(LenW), .Depth(Alphabet)) u_win_cnt (
    .clk, .we(wc_we), .waddr(wc_waddr), .wdata(wc_wdata),
    .raddr(wc_raddr), .rdata(wc_rdata)
  );

  mwc_ram #(.Width(8), .Depth(MaxText)) u_hist (
    .clk, .we(cmd.txt_wr), .waddr(txt_pos[PosW-1:0]), .wdata(8'(sym)),
    .raddr(left), .rdata(hist_rdata)
  );

  assign clr_last = (clr_idx == SymW'(Alphabet - 1));

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) begin
      hsym <= hist_rdata[SymW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_idx <= '0;
    end else if (cmd.clr_step && !clr_last) begin
      clr_idx <= clr_idx + SymW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      pat_len    <= '0;
      txt_pos    <= '0;
      left       <= '0;
      covered    <= '0;
      best_start <= '0;
      best_len   <= '0;
      ovf        <= 1'b0;
    end else begin
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.pat_wr) begin
        pat_len <= pat_len + LenW'(1);
      end
      if (cmd.txt_wr) begin
        txt_pos <= txt_pos + LenW'(1);
        if (pc_rdata != '0 && wc_inc <= pc_rdata) begin
          covered <= covered + LenW'(1);
        end
      end
      if (cmd.shrink_apply && stat.can_shrink) begin
        left <= left + PosW'(1);
      end
      if (cmd.record_best && (best_len == '0 || win_len < best_len)) begin
        best_len   <= win_len;
        best_start <= left;
      end
    end
  end

  // Window is [left, txt_pos - 1] once the byte is written.
  assign win_len = txt_pos - LenW'(left);

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      result.found         <= (best_len != '0);
      result.window_start  <= (best_len != '0) ? 12'(best_start) : '0;
      result.window_length <= (best_len != '0) ? 13'(best_len) : '0;
      result.overflow      <= ovf;
    end
  end

  always_comb begin
    stat.clr_done      = clr_last;
    stat.pat_full      = (pat_len >= LenW'(MaxText));
    stat.txt_full      = (txt_pos >= LenW'(MaxText));
    stat.text_started  = (txt_pos != '0);
    stat.pat_empty     = (pat_len == '0);
    stat.covered       = (covered == pat_len);
    stat.left_in_range = (LenW'(left) < txt_pos);
    stat.can_shrink    = (wc_rdata > pc_rdata) || (pc_rdata == '0);
  end
endmodule

FILE: hw/rtl/mwc_ctrl.sv
// ----------------------------------------------------------------------------
// mwc_ctrl
// Sequencer: one request at a time, counts read then written, window shrink.
// ----------------------------------------------------------------------------
`include "min_window_covering_pattern_assert.svh"
module mwc_ctrl
  import mwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);
  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StClear;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    in_ready       = 1'b0;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      StIdle: begin
        // An end request waits until the previous result has left.
        in_ready = !(action == ActEnd && out_valid);
        if (in_valid && in_ready) begin
          cmd.latch_in = 1'b1;
          case (action)
            ActPattern: begin
              if (stat.text_started) begin
                state_next = StIdle;
              end else if (stat.pat_full) begin
                cmd.set_ovf = 1'b1;
              end else begin
                state_next = StPatRd;
              end
            end
            ActText: begin
              if (stat.txt_full) begin
                cmd.set_ovf = 1'b1;
              end else begin
                state_next = StTxtRd;
              end
            end
            ActEnd: begin
              cmd.emit_load  = 1'b1;
              out_valid_next = 1'b1;
              state_next     = StEmit;
            end
            default: state_next = StIdle;
          endcase
        end
      end
      StEmit: begin
        cmd.clr_start = 1'b1;
        state_next    = StClear;
      end
      StClear: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = StIdle;
        end
      end
      StPatRd: begin
        cmd.pat_rd = 1'b1;
        state_next = StPatWr;
      end
      StPatWr: begin
        cmd.pat_wr = 1'b1;
        state_next = StIdle;
      end
      StTxtRd: begin
        cmd.txt_rd = 1'b1;
        state_next = StTxtWr;
      end
      StTxtWr: begin
        cmd.txt_wr = 1'b1;
        state_next = StHistRd;
      end
      StHistRd: begin
        if (stat.pat_empty || !stat.covered) begin
          state_next = StIdle;
        end else if (stat.left_in_range) begin
          state_next = StCntRd;
        end else begin
          cmd.record_best = 1'b1;
          state_next      = StIdle;
        end
      end
      StCntRd: begin
        cmd.cnt_rd = 1'b1;
        state_next = StCntChk;
      end
      StCntChk: begin
        cmd.shrink_apply = 1'b1;
        if (stat.can_shrink) begin
          state_next = StHistRd;
        end else begin
          cmd.record_best = 1'b1;
          state_next      = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  `MWC_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == StIdle)
  `MWC_ASSERT_NXT(a_end_clears, clk, rst, state == StEmit, state == StClear)
  `MWC_ASSERT_IMP(a_one_write, clk, rst, 1'b1, $onehot0({cmd.clr_step, cmd.pat_wr, cmd.txt_wr}))
  `MWC_ASSERT_IMP(a_rec_exit, clk, rst, cmd.record_best, state_next == StIdle)
endmodule

FILE: hw/rtl/min_window_covering_pattern.sv
// ----------------------------------------------------------------------------
// min_window_covering_pattern
// Shortest text window that covers every pattern byte, duplicates counted.
// ----------------------------------------------------------------------------
// Usage: send pattern requests (action 0), then text requests (action 1),
// then an end request (action 2) on the in channel. Only the end request
// yields a result on the out channel: found, start, length and overflow.
// A pattern request passes a count read and a count write state. A text
// request passes a count read, a write and a history read; once the pattern
// is covered, each byte the left edge passes adds a count read, a shrink check
// and a history read, and the edge stops at a failing check or the end of the
// text, passing each text byte at most once. Count reads and writes sit apart
// as each count memory has one read port. The end request loads the result
// register in its acceptance cycle; after the emit state a pass zeroes each
// count memory's 256 entries with no request taken, as it does after reset.
// Result valid holds until the receiver takes it; a further end request
// waits while the previous result is still pending, other requests proceed.
// ----------------------------------------------------------------------------
module min_window_covering_pattern
  import mwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  cmd_t  cmd;
  stat_t stat;

  mwc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .action(in_data.action),
    .out_valid, .out_ready, .stat, .cmd
  );

  mwc_datapath u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .result(out_data)
  );
endmodule
